// ===== src/vca_pkg.sv =====
// Package for the voice channel allocator: request codes, FSM states,
// beat layouts and default sizes. No dependencies.
package vca_pkg;

   localparam int DEF_CHANNELS = 16;
   localparam int DEF_SOUNDS   = 256;

   // request beat: tuser carries the request kind, tdata the payload
   localparam int REQ_TUSER_W = 2;
   localparam int REQ_TDATA_W = 56;
   localparam int SND_LSB     = 0;
   localparam int SND_W       = 8;
   localparam int LOADED_BIT  = 8;
   localparam int MAXP_LSB    = 9;
   localparam int MAXP_W      = 8;
   localparam int LEN_LSB     = 17;
   localparam int LEN_W       = 24;
   localparam int PRIO_LSB    = 41;
   localparam int PRIO_W      = 8;
   localparam int CHIDX_LSB   = 49;
   localparam int CHIDX_W     = 4;

   // response beat
   localparam int RSP_TDATA_W     = 8;
   localparam int RSP_GRANTED_BIT = 0;
   localparam int RSP_CHAN_LSB    = 1;
   localparam int RSP_CHAN_W      = 4;
   localparam int RSP_BUSY_BIT    = 5;

   localparam int ORDER_W = 32;

   typedef enum logic [1:0] {
      REQ_PLAY     = 2'd0,
      REQ_RELEASE  = 2'd1,
      REQ_FREE_ALL = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_COUNT,
      ST_OLDEST,
      ST_STEAL,
      ST_COMMIT,
      ST_DONE
   } state_type;

endpackage

// ===== src/voice_channel_allocator_unit.sv =====
// Voice channel allocator top level: sequencer, channel table, play counters.
// Depends on vca_pkg.
//
//  channel | dir | beat contents
//  --------+-----+-------------------------------------------------------------
//  req_*   | in  | tuser: request kind; tdata: sound, loaded, limit, length,
//          |     | priority, channel to release
//  rsp_*   | out | tdata: granted, assigned channel, replaced busy
//
// Play request, in order from the accepting cycle: idle, decode, a counting
// pass (CHANNELS reads, a drain of the read register, a decision), up to two
// search passes of the same form, a commit and a load of the response register.
// The passes walk the channel table through its single read port. Release,
// free-all and plays refused at decode go from decode straight to loading the
// response register. After reset the play counter store is swept to zero with
// req_tready low. A stalled response holds in the output register; the next
// request beat is still taken while it waits.
module voice_channel_allocator_unit #(
   parameter int CHANNELS = vca_pkg::DEF_CHANNELS,
   parameter int SOUNDS   = vca_pkg::DEF_SOUNDS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [1:0] req_type
   input  logic [vca_pkg::REQ_TUSER_W-1:0]  req_tuser,
   // [7:0] sound_id, [8] sound_loaded, [16:9] max_plays, [40:17] sample_length,
   // [48:41] priority_req, [52:49] channel_index, [55:53] zero
   input  logic [vca_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] granted, [4:1] assigned_channel, [5] replaced_busy, [7:6] zero
   output logic [vca_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int CW = $clog2(CHANNELS);
   localparam int SW = $clog2(SOUNDS);
   localparam logic [CW:0]   IDX_END  = (CW+1)'(CHANNELS);
   localparam logic [SW-1:0] CLR_LAST = SW'(SOUNDS - 1);

   // one channel table entry
   typedef struct packed {
      logic [vca_pkg::ORDER_W-1:0] order;
      logic [vca_pkg::LEN_W-1:0]   length;
      logic [vca_pkg::PRIO_W-1:0]  prio;
      logic [vca_pkg::SND_W-1:0]   sound;
   } voice_type;

   // ---------------------------------------------------------------- state
   vca_pkg::state_type     state_ff, state_in;
   vca_pkg::req_kind_type  kind_ff, kind_in;
   logic [vca_pkg::REQ_TDATA_W-1:0] req_data_ff, req_data_in;

   logic [CHANNELS-1:0]    busy_ff, busy_in;      // channel playing
   logic [SW-1:0]          clr_idx_ff, clr_idx_in;

   logic [CW:0]            idx_ff, idx_in;        // read issue pointer
   logic                   pipe_vld_ff, pipe_vld_in;
   logic [CW-1:0]          pipe_idx_ff, pipe_idx_in;

   logic [CW:0]            count_ff, count_in;
   logic                   free_found_ff, free_found_in;
   logic [CW-1:0]          free_slot_ff, free_slot_in;
   logic                   found_ff, found_in;
   logic [CW-1:0]          slot_ff, slot_in;
   logic [31:0]            best_ff, best_in;

   logic                   res_granted_ff, res_granted_in;
   logic                   res_busy_ff, res_busy_in;
   logic [vca_pkg::RSP_CHAN_W-1:0] res_chan_ff, res_chan_in;

   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [vca_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // memories
   voice_type              chan_mem [CHANNELS];
   voice_type              rd_word_ff;
   logic [vca_pkg::ORDER_W-1:0] ctr_mem [SOUNDS];
   logic [vca_pkg::ORDER_W-1:0] ctr_q_ff;

   logic                   chan_rd_en, chan_we, ctr_rd_en, ctr_we;
   voice_type              chan_wr_word;
   logic [SW-1:0]          ctr_wr_addr;
   logic [vca_pkg::ORDER_W-1:0] ctr_wr_data;

   // shared magnitude comparator
   logic [31:0]            cmp_a, cmp_b;
   logic                   cmp_gt;

   // ---------------------------------------------------------------- fields
   logic [vca_pkg::SND_W-1:0]   f_sound;
   logic                        f_loaded;
   logic [vca_pkg::MAXP_W-1:0]  f_maxp;
   logic [vca_pkg::LEN_W-1:0]   f_len;
   logic [vca_pkg::PRIO_W-1:0]  f_prio;
   logic [vca_pkg::CHIDX_W-1:0] f_chidx;
   logic [SW-1:0]               snd_addr;
   logic                        snd_ok, chan_ok;
   logic                        hit;
   logic [31:0]                 age;
   logic                        scan_done;

   assign f_sound  = req_data_ff[vca_pkg::SND_LSB   +: vca_pkg::SND_W];
   assign f_loaded = req_data_ff[vca_pkg::LOADED_BIT];
   assign f_maxp   = req_data_ff[vca_pkg::MAXP_LSB  +: vca_pkg::MAXP_W];
   assign f_len    = req_data_ff[vca_pkg::LEN_LSB   +: vca_pkg::LEN_W];
   assign f_prio   = req_data_ff[vca_pkg::PRIO_LSB  +: vca_pkg::PRIO_W];
   assign f_chidx  = req_data_ff[vca_pkg::CHIDX_LSB +: vca_pkg::CHIDX_W];

   assign snd_addr = SW'(f_sound);
   assign snd_ok   = 32'(f_sound) < 32'(SOUNDS);
   assign chan_ok  = 32'(f_chidx) < 32'(CHANNELS);

   // entry under evaluation belongs to the requested sound
   assign hit = busy_ff[pipe_idx_ff] && (rd_word_ff.sound == f_sound);
   // age of an instance, as a signed 32-bit quantity
   assign age = ctr_q_ff - rd_word_ff.order;
   assign scan_done = (idx_ff == IDX_END) && !pipe_vld_ff;

   assign cmp_gt = cmp_a > cmp_b;

   assign req_tready = (state_ff == vca_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      req_data_in    = req_data_ff;
      busy_in        = busy_ff;
      clr_idx_in     = clr_idx_ff;
      idx_in         = idx_ff;
      pipe_vld_in    = 1'b0;
      pipe_idx_in    = idx_ff[CW-1:0];
      count_in       = count_ff;
      free_found_in  = free_found_ff;
      free_slot_in   = free_slot_ff;
      found_in       = found_ff;
      slot_in        = slot_ff;
      best_in        = best_ff;
      res_granted_in = res_granted_ff;
      res_busy_in    = res_busy_ff;
      res_chan_in    = res_chan_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_tdata_in   = rsp_tdata_ff;
      chan_rd_en     = 1'b0;
      chan_we        = 1'b0;
      ctr_rd_en      = 1'b0;
      ctr_we         = 1'b0;
      ctr_wr_addr    = snd_addr;
      ctr_wr_data    = ctr_q_ff + 32'd1;
      chan_wr_word   = '{order: ctr_q_ff, length: f_len, prio: f_prio, sound: f_sound};
      cmp_a          = '0;
      cmp_b          = '0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         vca_pkg::ST_CLEAR: begin
            ctr_we      = 1'b1;
            ctr_wr_addr = clr_idx_ff;
            ctr_wr_data = '0;
            clr_idx_in  = clr_idx_ff + SW'(1);
            if (clr_idx_ff == CLR_LAST) begin
               state_in = vca_pkg::ST_IDLE;
            end
         end

         vca_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               kind_in     = vca_pkg::req_kind_type'(req_tuser);
               req_data_in = req_tdata;
               state_in    = vca_pkg::ST_DECODE;
            end
         end

         vca_pkg::ST_DECODE: begin
            res_granted_in = 1'b0;
            res_busy_in    = 1'b0;
            res_chan_in    = '0;
            state_in       = vca_pkg::ST_DONE;
            unique case (kind_ff)
               vca_pkg::REQ_PLAY: begin
                  if (f_loaded && snd_ok) begin
                     ctr_rd_en     = 1'b1;
                     idx_in        = '0;
                     count_in      = '0;
                     free_found_in = 1'b0;
                     state_in      = vca_pkg::ST_COUNT;
                  end
               end
               vca_pkg::REQ_RELEASE: begin
                  if (chan_ok) begin
                     busy_in[CW'(f_chidx)] = 1'b0;
                     res_granted_in        = 1'b1;
                  end
               end
               vca_pkg::REQ_FREE_ALL: begin
                  busy_in        = '0;
                  res_granted_in = 1'b1;
               end
               default: begin
                  res_granted_in = 1'b0;
               end
            endcase
         end

         // pass 1: count instances of the sound, note the first free channel
         vca_pkg::ST_COUNT: begin
            if (idx_ff != IDX_END) begin
               chan_rd_en  = 1'b1;
               pipe_vld_in = 1'b1;
               idx_in      = idx_ff + (CW+1)'(1);
            end
            if (pipe_vld_ff) begin
               if (hit) begin
                  count_in = count_ff + (CW+1)'(1);
               end
               if (!busy_ff[pipe_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = pipe_idx_ff;
               end
            end
            if (scan_done) begin
               idx_in   = '0;
               found_in = 1'b0;
               if (32'(count_ff) >= 32'(f_maxp)) begin
                  best_in  = '0;
                  state_in = vca_pkg::ST_OLDEST;
               end else if (free_found_ff) begin
                  slot_in  = free_slot_ff;
                  state_in = vca_pkg::ST_COMMIT;
               end else begin
                  best_in  = '1;
                  state_in = vca_pkg::ST_STEAL;
               end
            end
         end

         // pass 2a: oldest instance of the sound, strictly positive age
         vca_pkg::ST_OLDEST: begin
            cmp_a = age;
            cmp_b = best_ff;
            if (idx_ff != IDX_END) begin
               chan_rd_en  = 1'b1;
               pipe_vld_in = 1'b1;
               idx_in      = idx_ff + (CW+1)'(1);
            end
            if (pipe_vld_ff && hit && !age[31] && cmp_gt) begin
               found_in = 1'b1;
               slot_in  = pipe_idx_ff;
               best_in  = age;
            end
            if (scan_done) begin
               idx_in = '0;
               if (found_ff) begin
                  state_in = vca_pkg::ST_COMMIT;
               end else if (free_found_ff) begin
                  slot_in  = free_slot_ff;
                  state_in = vca_pkg::ST_COMMIT;
               end else begin
                  best_in  = '1;
                  state_in = vca_pkg::ST_STEAL;
               end
            end
         end

         // pass 2b: shortest sample among lower-priority channels
         vca_pkg::ST_STEAL: begin
            cmp_a = best_ff;
            cmp_b = 32'(rd_word_ff.length);
            if (idx_ff != IDX_END) begin
               chan_rd_en  = 1'b1;
               pipe_vld_in = 1'b1;
               idx_in      = idx_ff + (CW+1)'(1);
            end
            if (pipe_vld_ff && cmp_gt && (f_prio > rd_word_ff.prio)) begin
               found_in = 1'b1;
               slot_in  = pipe_idx_ff;
               best_in  = cmp_b;
            end
            if (scan_done) begin
               idx_in   = '0;
               state_in = found_ff ? vca_pkg::ST_COMMIT : vca_pkg::ST_DONE;
            end
         end

         vca_pkg::ST_COMMIT: begin
            chan_we        = 1'b1;
            ctr_we         = 1'b1;
            busy_in[slot_ff] = 1'b1;
            res_granted_in = 1'b1;
            res_busy_in    = busy_ff[slot_ff];
            res_chan_in    = vca_pkg::RSP_CHAN_W'(slot_ff);
            state_in       = vca_pkg::ST_DONE;
         end

         vca_pkg::ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = '0;
               rsp_tdata_in[vca_pkg::RSP_GRANTED_BIT] = res_granted_ff;
               rsp_tdata_in[vca_pkg::RSP_CHAN_LSB +: vca_pkg::RSP_CHAN_W] = res_chan_ff;
               rsp_tdata_in[vca_pkg::RSP_BUSY_BIT] = res_busy_ff;
               state_in = vca_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = vca_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= vca_pkg::ST_CLEAR;
         busy_ff       <= '0;
         clr_idx_ff    <= '0;
         pipe_vld_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         clr_idx_ff    <= clr_idx_in;
         pipe_vld_ff   <= pipe_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      req_data_ff    <= req_data_in;
      idx_ff         <= idx_in;
      pipe_idx_ff    <= pipe_idx_in;
      count_ff       <= count_in;
      free_found_ff  <= free_found_in;
      free_slot_ff   <= free_slot_in;
      found_ff       <= found_in;
      slot_ff        <= slot_in;
      best_ff        <= best_in;
      res_granted_ff <= res_granted_in;
      res_busy_ff    <= res_busy_in;
      res_chan_ff    <= res_chan_in;
      rsp_tdata_ff   <= rsp_tdata_in;
   end

   // channel table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (chan_we) begin
         chan_mem[slot_ff] <= chan_wr_word;
      end
      if (chan_rd_en) begin
         rd_word_ff <= chan_mem[idx_ff[CW-1:0]];
      end
   end

   // per-sound play counters
   always_ff @(posedge clock) begin
      if (ctr_we) begin
         ctr_mem[ctr_wr_addr] <= ctr_wr_data;
      end
      if (ctr_rd_en) begin
         ctr_q_ff <= ctr_mem[snd_addr];
      end
   end

endmodule

// ===== src/vca_checker.sv =====
// Port-level checks for voice_channel_allocator_unit, attached by bind.
// Depends on vca_pkg.
module vca_port_checks (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [vca_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input logic [vca_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [vca_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat dropped or changed under stall");

   // one request at a time: busy right after a request beat
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in progress");

   // refused requests carry no channel and no replacement flag
   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[vca_pkg::RSP_GRANTED_BIT] |->
      rsp_tdata[vca_pkg::RSP_BUSY_BIT:vca_pkg::RSP_CHAN_LSB] == '0)
      else $error("refused response with channel or busy set");

   // padding bits stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[vca_pkg::RSP_TDATA_W-1:vca_pkg::RSP_BUSY_BIT+1] == '0)
      else $error("response padding not zero");

endmodule

bind voice_channel_allocator_unit vca_port_checks u_vca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/vca_checker.sv =====
// Scoreboard for the voice channel allocator: mirrors the channel table and play
// counters, predicts each response beat and compares it field by field.
// Depends on vca_pkg.
module vca_checker #(
   parameter int CHANNELS = vca_pkg::DEF_CHANNELS,
   parameter int SOUNDS   = vca_pkg::DEF_SOUNDS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [vca_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic [vca_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [vca_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                              fail_count,
   output int                              rsp_seen
);

   typedef struct packed {
      logic       granted;
      logic [3:0] chan;
      logic       busy;
   } grant_type;

   localparam logic [8:0] VOICE_FREE = 9'h100;

   logic [8:0]  voice_sound [CHANNELS];
   logic [7:0]  voice_prio  [CHANNELS];
   logic [23:0] voice_len   [CHANNELS];
   logic [31:0] voice_order [CHANNELS];
   logic [31:0] play_count  [SOUNDS];
   grant_type   grant_q [$];

   // same sound at its limit: oldest instance; else first free; else steal
   function automatic int choose_channel(logic [7:0] snd, logic [7:0] limit,
                                         logic [7:0] prio);
      int          slot;
      int unsigned n;
      logic [31:0] best;
      logic [31:0] age;
      slot = -1;
      n    = 0;
      for (int c = 0; c < CHANNELS; c++)
         if (voice_sound[c] == {1'b0, snd}) n++;
      if (n >= limit) begin
         best = '0;
         for (int c = 0; c < CHANNELS; c++) begin
            age = play_count[snd] - voice_order[c];
            if (voice_sound[c] == {1'b0, snd} && age < 32'h8000_0000 && age > best) begin
               slot = c;
               best = age;
            end
         end
      end
      for (int c = 0; c < CHANNELS && slot < 0; c++)
         if (voice_sound[c] == VOICE_FREE) slot = c;
      if (slot < 0) begin
         best = '1;
         for (int c = 0; c < CHANNELS; c++) begin
            if ({8'h00, voice_len[c]} < best && prio > voice_prio[c]) begin
               slot = c;
               best = {8'h00, voice_len[c]};
            end
         end
      end
      return slot;
   endfunction

   function automatic grant_type predict_grant(logic [vca_pkg::REQ_TUSER_W-1:0] kind,
                                               logic [vca_pkg::REQ_TDATA_W-1:0] d);
      grant_type   g;
      int          slot;
      logic [7:0]  snd;
      logic [7:0]  prio;
      logic [3:0]  chidx;
      snd   = d[vca_pkg::SND_LSB +: vca_pkg::SND_W];
      prio  = d[vca_pkg::PRIO_LSB +: vca_pkg::PRIO_W];
      chidx = d[vca_pkg::CHIDX_LSB +: vca_pkg::CHIDX_W];
      g     = '0;
      case (kind)
         vca_pkg::REQ_PLAY: begin
            if (d[vca_pkg::LOADED_BIT] && snd < SOUNDS) begin
               slot = choose_channel(snd, d[vca_pkg::MAXP_LSB +: vca_pkg::MAXP_W], prio);
               if (slot >= 0) begin
                  g.busy             = voice_sound[slot] != VOICE_FREE;
                  voice_sound[slot]  = {1'b0, snd};
                  voice_prio[slot]   = prio;
                  voice_len[slot]    = d[vca_pkg::LEN_LSB +: vca_pkg::LEN_W];
                  voice_order[slot]  = play_count[snd];
                  play_count[snd]    = play_count[snd] + 32'd1;
                  g.granted          = 1'b1;
                  g.chan             = slot[3:0];
               end
            end
         end
         vca_pkg::REQ_RELEASE: begin
            if (chidx < CHANNELS) begin
               voice_sound[chidx] = VOICE_FREE;
               g.granted          = 1'b1;
            end
         end
         vca_pkg::REQ_FREE_ALL: begin
            for (int c = 0; c < CHANNELS; c++) voice_sound[c] = VOICE_FREE;
            g.granted = 1'b1;
         end
         default: ;
      endcase
      return g;
   endfunction

   initial begin
      fail_count = 0;
      rsp_seen   = 0;
   end

   always @(posedge clock) begin
      grant_type want;
      grant_type got;
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            voice_sound[c] = VOICE_FREE;
            voice_prio[c]  = '0;
            voice_len[c]   = '0;
            voice_order[c] = '0;
         end
         for (int s = 0; s < SOUNDS; s++) play_count[s] = '0;
         grant_q.delete();
      end else begin
         // response first: it always belongs to an earlier request
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen <= rsp_seen + 1;
            got.granted = rsp_tdata[vca_pkg::RSP_GRANTED_BIT];
            got.chan    = rsp_tdata[vca_pkg::RSP_CHAN_LSB +: vca_pkg::RSP_CHAN_W];
            got.busy    = rsp_tdata[vca_pkg::RSP_BUSY_BIT];
            if (grant_q.size() == 0) begin
               $error("response beat with no request outstanding: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = grant_q.pop_front();
               if (got.granted !== want.granted) begin
                  $error("granted: expected %0d, got %0d", want.granted, got.granted);
                  fail_count++;
               end
               if (got.chan !== want.chan) begin
                  $error("assigned_channel: expected %0d, got %0d", want.chan, got.chan);
                  fail_count++;
               end
               if (got.busy !== want.busy) begin
                  $error("replaced_busy: expected %0d, got %0d", want.busy, got.busy);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            grant_q.push_back(predict_grant(req_tuser, req_tdata));
      end
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for voice_channel_allocator_unit: clock, reset, request
// stimulus, response stalls, watchdog, verdict. Depends on vca_pkg, vca_checker too.
module tb_top;

   localparam logic [1:0] REQ_UNUSED = 2'd3;   // reserved kind, answered with no grant
   localparam int         RANDOM_BEATS = 1650;
   localparam int         IDLE_LIMIT   = 3000;  // cycles with no beat moving
   localparam int         TAIL_CYCLES  = 64;    // longer than the slowest play

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [vca_pkg::REQ_TUSER_W-1:0] req_tuser  = '0;
   logic [vca_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [vca_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   int          fail_count;
   int          rsp_seen;
   int          beats_sent = 0;
   int          idle_cycles = 0;
   int unsigned stall_left = 0;
   bit          calm = 1'b0;   // when set, neither side idles

   always #5 clock = ~clock;

   voice_channel_allocator_unit #(
      .CHANNELS (vca_pkg::DEF_CHANNELS),
      .SOUNDS   (vca_pkg::DEF_SOUNDS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   vca_checker #(
      .CHANNELS (vca_pkg::DEF_CHANNELS),
      .SOUNDS   (vca_pkg::DEF_SOUNDS)
   ) u_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .rsp_seen   (rsp_seen)
   );

   // Idle length: mostly none or short, now and then long enough to cover a
   // whole play search.
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 88) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [vca_pkg::REQ_TDATA_W-1:0] pack_req(
         logic [7:0] snd, logic loaded, logic [7:0] limit, logic [23:0] len,
         logic [7:0] prio, logic [3:0] chidx);
      logic [vca_pkg::REQ_TDATA_W-1:0] d;
      d = '0;   // top pad bits stay zero
      d[vca_pkg::SND_LSB +: vca_pkg::SND_W]     = snd;
      d[vca_pkg::LOADED_BIT]                    = loaded;
      d[vca_pkg::MAXP_LSB +: vca_pkg::MAXP_W]   = limit;
      d[vca_pkg::LEN_LSB +: vca_pkg::LEN_W]     = len;
      d[vca_pkg::PRIO_LSB +: vca_pkg::PRIO_W]   = prio;
      d[vca_pkg::CHIDX_LSB +: vca_pkg::CHIDX_W] = chidx;
      return d;
   endfunction

   // Present one beat, hold it until taken, then maybe idle. tvalid stays high
   // straight into the next beat when no gap is drawn.
   task automatic send_beat(logic [1:0] kind, logic [vca_pkg::REQ_TDATA_W-1:0] d);
      int unsigned gap;
      req_tuser  <= kind;
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      gap = calm ? 0 : idle_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off until every response owed has been taken; the last beat must not
   // be offered again meanwhile.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (rsp_seen != beats_sent) @(posedge clock);
   endtask

   // Response back-pressure: random stalls, none while calm.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= idle_len();
      end
   end

   // Watchdog: a hung handshake on either channel ends the run.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int unsigned r;
      logic [1:0]  kind;
      logic [7:0]  snd;
      logic [7:0]  limit;
      logic [23:0] len;
      logic [7:0]  prio;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: corner cases on a known table ----
      // unloaded sound is refused
      send_beat(vca_pkg::REQ_PLAY, pack_req(8'd0, 1'b0, 8'd1, 24'd100, 8'd10, 4'd0));
      // releasing a channel that is already free still grants
      send_beat(vca_pkg::REQ_RELEASE, pack_req(8'd0, 1'b0, 8'd0, 24'd0, 8'd0, 4'd15));
      // reserved kind with every field at its top value
      send_beat(REQ_UNUSED, pack_req(8'hFF, 1'b1, 8'hFF, 24'hFF_FFFF, 8'hFF, 4'hF));
      // top sound, top limit, top length, top priority: first free channel
      send_beat(vca_pkg::REQ_PLAY, pack_req(8'hFF, 1'b1, 8'hFF, 24'hFF_FFFF, 8'hFF, 4'd0));
      // zero limit with no instance playing: ordinary allocation
      send_beat(vca_pkg::REQ_PLAY, pack_req(8'd1, 1'b1, 8'd0, 24'd0, 8'd0, 4'd0));
      // limit of one reached: own instance is replaced
      send_beat(vca_pkg::REQ_PLAY, pack_req(8'd1, 1'b1, 8'd1, 24'd7, 8'd3, 4'd0));
      send_beat(vca_pkg::REQ_PLAY, pack_req(8'd1, 1'b1, 8'd2, 24'd7, 8'd3, 4'd0));
      // limit of two reached: the older of the two goes
      send_beat(vca_pkg::REQ_PLAY, pack_req(8'd1, 1'b1, 8'd2, 24'd7, 8'd3, 4'd0));
      // fill the rest of the table, several equal short lengths for a tie
      for (int s = 2; s <= 14; s++)
         send_beat(vca_pkg::REQ_PLAY,
                   pack_req(8'(s), 1'b1, 8'hFF, (s < 8) ? 24'd5 : 24'd900, 8'd20, 4'd0));
      // table full and nothing of lower priority: refused
      send_beat(vca_pkg::REQ_PLAY, pack_req(8'd30, 1'b1, 8'hFF, 24'd1, 8'd0, 4'd0));
      // steal: shortest length below priority, lowest channel on a tie
      send_beat(vca_pkg::REQ_PLAY, pack_req(8'd31, 1'b1, 8'd4, 24'd2, 8'd100, 4'd0));
      send_beat(vca_pkg::REQ_RELEASE, pack_req(8'd0, 1'b0, 8'd0, 24'd0, 8'd0, 4'd0));
      send_beat(vca_pkg::REQ_FREE_ALL, pack_req(8'd0, 1'b0, 8'd0, 24'd0, 8'd0, 4'd0));
      drain();

      // ---- random: mostly plays over a small set of sounds so that limits,
      // replacement and stealing are hit often; releases keep the table moving
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 150 == 0) calm <= ($urandom_range(0, 3) == 0);
         // sender holds off until everything owed is back
         if (i == RANDOM_BEATS / 2 || $urandom_range(0, 299) == 0) drain();

         r = $urandom_range(0, 99);
         if (r < 3)       kind = vca_pkg::REQ_FREE_ALL;
         else if (r < 5)  kind = REQ_UNUSED;
         else if (r < 17) kind = vca_pkg::REQ_RELEASE;
         else             kind = vca_pkg::REQ_PLAY;

         snd = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 11))
                                          : 8'($urandom_range(0, 255));
         r = $urandom_range(0, 99);
         if (r < 10)      limit = 8'd0;
         else if (r < 70) limit = 8'($urandom_range(1, 4));
         else             limit = 8'($urandom_range(0, 255));
         len = ($urandom_range(0, 9) < 4) ? 24'($urandom_range(0, 15)) : 24'($urandom);
         r = $urandom_range(0, 9);
         if (r == 0)      prio = 8'd0;
         else if (r == 1) prio = 8'hFF;
         else             prio = 8'($urandom_range(0, 255));

         send_beat(kind, pack_req(snd, $urandom_range(0, 19) != 0, limit, len, prio,
                                  4'($urandom_range(0, 15))));
      end

      req_tvalid <= 1'b0;
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
src/vca_pkg.sv
src/voice_channel_allocator_unit.sv
src/vca_checker.sv
tb/vca_checker.sv
tb/tb_top.sv
